/* rtl/msst_pkg.sv */
// Shared definitions for the multi-stack store.
// Holds field widths, command and status codes, and default sizes.
// No dependencies; compile this file first.
package msst_pkg;

	localparam int CMD_W = 2;
	localparam int IDX_W = 7;
	localparam int VAL_W = 30;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int DEF_NUM_STACKS  = 128;
	localparam int DEF_STACK_DEPTH = 1024;

endpackage

/* rtl/msst_level_store.sv */
// Fill-level memory with one valid bit per stack and a registered read port.
// An entry never written since reset reads as zero.
// No package dependencies.
module msst_level_store #(
	parameter int NUM_ENTRIES = 128,
	parameter int LVL_W       = 11,
	parameter int AW          = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [LVL_W-1:0] rd_level,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [LVL_W-1:0] wr_level
);

	logic [LVL_W-1:0]       mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] vld_q;
	logic [LVL_W-1:0]       rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_level;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_level = rd_vld_q ? rd_data_q : '0;

endmodule

/* rtl/msst_entry_store.sv */
// Stack entry memory: one write port and one registered read port.
// Contents are undefined until written.
// No package dependencies.
module msst_entry_store #(
	parameter int DEPTH  = 131072,
	parameter int AW     = 17,
	parameter int DATA_W = 30
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/multi_stack_store.sv */
// Top level of the multi-stack store: input stage, command logic and result register.
// Depends on msst_pkg, msst_level_store and msst_entry_store.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   command, stack_index, value, pop_count, position
//   out      output     out_valid/out_stall read_value, status
//
// One command per cycle unless the input stalls; each read result is registered.
// Memories are read as a command is taken, written as it executes, with forwarding.
// Reset clears all fill levels at once through per-stack valid bits.
// A read waiting on a stalled result register stalls the input; other commands never wait.
module multi_stack_store
	import msst_pkg::*;
#(
	parameter int NUM_STACKS  = DEF_NUM_STACKS,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] command,
	input  logic [IDX_W-1:0] stack_index,
	input  logic [VAL_W-1:0] value,
	input  logic [VAL_W-1:0] pop_count,
	input  logic [VAL_W-1:0] position,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VAL_W-1:0] read_value,
	output logic             status
);

	localparam int LIVE  = (NUM_STACKS < (1 << IDX_W)) ? NUM_STACKS : (1 << IDX_W);
	localparam int LAW   = (LIVE > 1) ? $clog2(LIVE) : 1;
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int POS_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int EDEP  = LIVE * STACK_DEPTH;
	localparam int EAW   = (EDEP > 1) ? $clog2(EDEP) : 1;

	logic             accept;
	logic             fire;
	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [VAL_W-1:0] value_s1;
	logic [VAL_W-1:0] count_s1;
	logic [VAL_W-1:0] pos_s1;
	logic [EAW-1:0]   raddr_s1;

	logic [EAW-1:0]   in_raddr;
	logic [LVL_W-1:0] lvl_rd;
	logic [VAL_W-1:0] entry_rd;

	logic             lfw_vld_q;
	logic [IDX_W-1:0] lfw_idx_q;
	logic [LVL_W-1:0] lfw_lvl_q;
	logic             efw_vld_q;
	logic [EAW-1:0]   efw_addr_q;
	logic [VAL_W-1:0] efw_data_q;

	logic             idx_ok;
	logic [LVL_W-1:0] cur_lvl;
	logic             do_push;
	logic             do_pop;
	logic             lvl_we;
	logic [LVL_W-1:0] new_lvl;
	logic [EAW-1:0]   waddr;
	logic             rd_ok;
	logic [VAL_W-1:0] rd_word;
	logic             is_read;

	logic             out_valid_q;
	logic [VAL_W-1:0] read_value_q;
	logic             status_q;

	assign is_read  = (cmd_s1 == CMD_READ);
	assign fire     = valid_s1 && !(is_read && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	assign in_raddr = EAW'(32'(stack_index) * 32'(STACK_DEPTH) + 32'(position[POS_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= command;
			idx_s1   <= stack_index;
			value_s1 <= value;
			count_s1 <= pop_count;
			pos_s1   <= position;
			raddr_s1 <= in_raddr;
		end
	end

	msst_level_store #(
		.NUM_ENTRIES(LIVE),
		.LVL_W      (LVL_W),
		.AW         (LAW)
	) u_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (stack_index[LAW-1:0]),
		.rd_level(lvl_rd),
		.wr_en   (lvl_we),
		.wr_addr (idx_s1[LAW-1:0]),
		.wr_level(new_lvl)
	);

	msst_entry_store #(
		.DEPTH (EDEP),
		.AW    (EAW),
		.DATA_W(VAL_W)
	) u_entry (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(in_raddr),
		.rd_data(entry_rd),
		.wr_en  (do_push),
		.wr_addr(waddr),
		.wr_data(value_s1)
	);

	always_comb begin
		idx_ok  = (32'(idx_s1) < LIVE);
		cur_lvl = (lfw_vld_q && (lfw_idx_q == idx_s1)) ? lfw_lvl_q : lvl_rd;
		do_push = fire && (cmd_s1 == CMD_PUSH) && idx_ok && (32'(cur_lvl) < STACK_DEPTH);
		do_pop  = fire && (cmd_s1 == CMD_POP) && idx_ok;
		lvl_we  = do_push || do_pop;
		if (do_push) begin
			new_lvl = cur_lvl + LVL_W'(1);
		end else if (count_s1 >= VAL_W'(cur_lvl)) begin
			new_lvl = '0;
		end else begin
			new_lvl = cur_lvl - count_s1[LVL_W-1:0];
		end
		waddr   = EAW'(32'(idx_s1) * 32'(STACK_DEPTH) + 32'(cur_lvl));
		rd_ok   = idx_ok && (pos_s1 < VAL_W'(cur_lvl));
		rd_word = (efw_vld_q && (efw_addr_q == raddr_s1)) ? efw_data_q : entry_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfw_vld_q <= 1'b0;
			efw_vld_q <= 1'b0;
		end else begin
			if (lvl_we) begin
				lfw_vld_q <= 1'b1;
			end
			if (do_push) begin
				efw_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lfw_idx_q <= idx_s1;
			lfw_lvl_q <= new_lvl;
		end
		if (do_push) begin
			efw_addr_q <= waddr;
			efw_data_q <= value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_read) begin
			read_value_q <= rd_ok ? rd_word : '0;
			status_q     <= rd_ok ? STATUS_OK : STATUS_ERR;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

/* rtl/msst_checker.sv */
// Port-level checks for the multi-stack store, bound to the top level.
// Depends on msst_pkg and multi_stack_store.
module msst_checker
	import msst_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [CMD_W-1:0] command,
	input logic             out_valid,
	input logic             out_stall,
	input logic [VAL_W-1:0] read_value,
	input logic             status
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
	else $error("Stalled result transaction changed or was dropped.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_ERR) |-> (read_value == '0))
	else $error("Failed read returned a nonzero value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("Input stalled while the result register was free.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && (command == CMD_READ), 2))
	else $error("Result appeared without a read transaction two cycles earlier.");

endmodule

bind multi_stack_store msst_checker u_msst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.command   (command),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_value(read_value),
	.status    (status)
);

/* tb/sv/tb_multi_stack_store.sv */
// Self-checking testbench for multi_stack_store: directed, fill-to-full and random traffic.
// A scoreboard class mirrors every stack and checks each read result in order.
// Depends on msst_pkg and the multi_stack_store RTL.
`timescale 1ns / 100ps

module tb_multi_stack_store;
	import msst_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RAND_ITEMS = 60;
	localparam int CALM_ITEMS = 20;
	localparam int HOLD_CYCLES = 100;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [VAL_W-1:0] rd_value;
		logic             rd_status;
	} read_reply_t;

	class stack_mirror;
		int unsigned      fill_lvl [DEF_NUM_STACKS];
		logic [VAL_W-1:0] words [DEF_NUM_STACKS][DEF_STACK_DEPTH];
		read_reply_t      pending_reads [$];
		int               mismatches;

		function new();
			foreach (fill_lvl[i]) fill_lvl[i] = 0;
			mismatches = 0;
		endfunction

		function void note_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
				logic [VAL_W-1:0] val, logic [VAL_W-1:0] cnt, logic [VAL_W-1:0] pos);
			read_reply_t reply;
			case (cmd)
				CMD_PUSH: begin
					if (fill_lvl[idx] < DEF_STACK_DEPTH) begin
						words[idx][fill_lvl[idx]] = val;
						fill_lvl[idx]++;
					end
				end
				CMD_POP: begin
					fill_lvl[idx] = (cnt >= fill_lvl[idx]) ? 0 : fill_lvl[idx] - cnt;
				end
				CMD_READ: begin
					if (pos < fill_lvl[idx])
						reply = '{words[idx][pos], STATUS_OK};
					else
						reply = '{'0, STATUS_ERR};
					pending_reads = {pending_reads, reply};
				end
				default: ;
			endcase
		endfunction

		function void check_read(logic [VAL_W-1:0] rv, logic st);
			read_reply_t exp_reply;
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected read result, expected none, actual %h/%b", $time, rv, st);
				mismatches++;
			end else begin
				exp_reply = pending_reads.pop_front();
				if (rv !== exp_reply.rd_value) begin
					$display("%0t: read_value mismatch, expected %h, actual %h", $time,
						exp_reply.rd_value, rv);
					mismatches++;
				end
				if (st !== exp_reply.rd_status) begin
					$display("%0t: status mismatch, expected %b, actual %b", $time,
						exp_reply.rd_status, st);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CMD_W-1:0] command = '0;
	logic [IDX_W-1:0] stack_index = '0;
	logic [VAL_W-1:0] value = '0;
	logic [VAL_W-1:0] pop_count = '0;
	logic [VAL_W-1:0] position = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [VAL_W-1:0] read_value;
	logic             status;

	stack_mirror sb;
	bit          calm = 1'b0;
	bit          hold_now = 1'b0;
	int          idle_cycles = 0;

	multi_stack_store i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.stack_index (stack_index),
		.value       (value),
		.pop_count   (pop_count),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.status      (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [VAL_W-1:0] rand_word();
		return VAL_W'($urandom);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return rand_word();
		endcase
	endfunction

	task automatic issue(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] s,
			input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] n, input logic [VAL_W-1:0] p);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		stack_index <= s;
		value <= v;
		pop_count <= n;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_cmd(c, s, v, n, p);
	endtask

	task automatic directed_cases();
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), '0);
		issue(CMD_PUSH, 7'd0, '1, rand_word(), rand_word());
		issue(CMD_PUSH, 7'd0, '0, rand_word(), rand_word());
		issue(CMD_PUSH, 7'd0, 30'h1555_5555, rand_word(), rand_word());
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd0);
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd2);
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd3);
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), '1);
		issue(CMD_POP, 7'd0, rand_word(), '0, rand_word());
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd2);
		issue(CMD_POP, 7'd0, rand_word(), 30'd1, rand_word());
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd2);
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd1);
		issue(CMD_POP, 7'd0, rand_word(), '1, rand_word());
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd0);
		issue(CMD_PUSH, 7'd127, 30'h2AAA_AAAA, rand_word(), rand_word());
		issue(CMD_READ, 7'd127, rand_word(), rand_word(), 30'd0);
		issue(CMD_UNUSED, 7'd127, '1, '1, '1);
		issue(CMD_READ, 7'd127, rand_word(), rand_word(), 30'd0);
		issue(CMD_POP, 7'd127, rand_word(), 30'd5, rand_word());
		issue(CMD_READ, 7'd127, rand_word(), rand_word(), 30'd0);
		issue(CMD_PUSH, 7'd0, 30'd1, rand_word(), rand_word());
		issue(CMD_POP, 7'd0, rand_word(), 30'd1, rand_word());
		issue(CMD_READ, 7'd0, rand_word(), rand_word(), 30'd0);
	endtask

	// One stack is driven past its depth so that pushes to a full stack are dropped.
	task automatic fill_one_stack();
		logic [IDX_W-1:0] s;
		int unsigned      lvl;
		s = IDX_W'($urandom_range(1, 126));
		for (int k = 0; k < DEF_STACK_DEPTH + 3; k++) begin
			if ($urandom_range(0, 31) == 0) begin
				lvl = sb.fill_lvl[s];
				issue(CMD_READ, s, rand_word(), rand_word(),
					VAL_W'((lvl > 0) ? $urandom_range(0, lvl - 1) : 0));
			end
			issue(CMD_PUSH, s, pick_value(), rand_word(), rand_word());
		end
		issue(CMD_READ, s, rand_word(), rand_word(), 30'd0);
		issue(CMD_READ, s, rand_word(), rand_word(), VAL_W'(DEF_STACK_DEPTH - 1));
		issue(CMD_READ, s, rand_word(), rand_word(), VAL_W'(DEF_STACK_DEPTH));
		issue(CMD_POP, s, rand_word(), VAL_W'($urandom_range(1, 900)), rand_word());
		issue(CMD_READ, s, rand_word(), rand_word(), 30'd0);
	endtask

	task automatic random_traffic();
		logic [IDX_W-1:0] hot [6];
		logic [IDX_W-1:0] s;
		logic [VAL_W-1:0] p;
		logic [VAL_W-1:0] n;
		int unsigned      lvl;
		int unsigned      r;
		int               done;
		int               tries;
		done = 0;
		tries = 0;
		while (done < RAND_ITEMS) begin
			if (tries % 200 == 0)
				foreach (hot[k]) hot[k] = IDX_W'($urandom_range(0, DEF_NUM_STACKS - 1));
			tries++;
			calm = (done >= RAND_ITEMS - CALM_ITEMS);
			if (done == 15) hold_now = 1'b1;
			s = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 5)] :
				IDX_W'($urandom_range(0, DEF_NUM_STACKS - 1));
			lvl = sb.fill_lvl[s];
			r = $urandom_range(0, 99);
			if (r < 45) begin
				issue(CMD_PUSH, s, pick_value(), rand_word(), rand_word());
				done++;
			end else if (r < 80) begin
				if (lvl > 0 && $urandom_range(0, 3) != 0)
					p = VAL_W'($urandom_range(0, lvl - 1));
				else
					case ($urandom_range(0, 3))
						0: p = VAL_W'(lvl);
						1: p = VAL_W'(lvl + $urandom_range(1, 4));
						2: p = '1;
						default: p = rand_word();
					endcase
				issue(CMD_READ, s, rand_word(), rand_word(), p);
				done++;
			end else if (r < 95) begin
				case ($urandom_range(0, 19))
					0, 1, 2: n = VAL_W'(lvl);
					3, 4: n = rand_word();
					5: n = '1;
					default: n = VAL_W'($urandom_range(0, 3));
				endcase
				issue(CMD_POP, s, rand_word(), n, rand_word());
				done++;
			end else begin
				issue(CMD_UNUSED, s, rand_word(), rand_word(), rand_word());
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_cases();
		fill_one_stack();
		random_traffic();
		in_valid <= 1'b0;
		while (sb.pending_reads.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// The receiver stalls in random bursts and once holds off long enough to back up the input.
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_now && !held) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_read(read_value, status);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* files.f */
rtl/msst_pkg.sv
rtl/msst_level_store.sv
rtl/msst_entry_store.sv
rtl/multi_stack_store.sv
rtl/msst_checker.sv
tb/sv/tb_multi_stack_store.sv
